FILE: sv/msp_pkg.sv
// Package for the multi-stack shared pool: sizes, codes and the link store request.
// Used by the top level, the link store and the testbench; depends on nothing.
`default_nettype none

package msp_pkg;

    localparam int NUM_STACKS = 8;
    localparam int POOL_SLOTS = 64;

    localparam int SEL_W  = 3;
    localparam int DATA_W = 32;
    localparam int IDX_W  = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
    localparam int PTR_W  = $clog2(POOL_SLOTS + 1);
    localparam int HSEL_W = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;

    localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(POOL_SLOTS);

    typedef enum logic {
        KIND_PUSH = 1'b0,
        KIND_POP  = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        STAT_DONE  = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } status_t;

    typedef enum logic {
        S_IDLE,
        S_COMMIT
    } state_t;

    typedef struct packed {
        logic             re;
        logic [IDX_W-1:0] raddr;
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [PTR_W-1:0] wdata;
    } link_req_t;

endpackage

`default_nettype wire

FILE: sv/multi_stack_shared_pool.sv
// An accepted item moves to the commit state, from which its result word, with done high,
// is registered; busy is high for the one cycle in between.
// No new item is taken while busy, because of the dependent read and write of the
// link store (read at acceptance, rewritten in the commit cycle).
// Reset: all stacks empty, free list runs through the slots in order; no clearing pass.
// Top level of the multi-stack shared pool; depends on msp_pkg, msp_ram, msp_link_store.
`default_nettype none

module multi_stack_shared_pool (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic                        kind,
    input  wire logic [msp_pkg::SEL_W-1:0]   stack_sel,
    input  wire logic signed [31:0]          push_value,
    output logic                             done,
    output logic [1:0]                       status,
    output logic signed [31:0]               pop_value
);

    msp_pkg::state_t                state_reg, state_next;
    logic [msp_pkg::PTR_W-1:0]      stack_head_reg [msp_pkg::NUM_STACKS];
    logic [msp_pkg::PTR_W-1:0]      stack_head_next [msp_pkg::NUM_STACKS];
    logic [msp_pkg::PTR_W-1:0]      free_head_reg, free_head_next;
    logic                           ok_reg, ok_next;
    logic                           done_reg, done_next;
    msp_pkg::status_t               status_reg, status_next;
    logic [msp_pkg::DATA_W-1:0]     pop_value_reg, pop_value_next;

    msp_pkg::kind_t                 kind_reg;
    logic [msp_pkg::SEL_W-1:0]      sel_reg;
    logic [msp_pkg::DATA_W-1:0]     value_reg;
    logic [msp_pkg::PTR_W-1:0]      slot_reg, slot_next;

    logic                           accept;
    logic                           in_sel_ok;
    logic [msp_pkg::PTR_W-1:0]      in_head;
    logic [msp_pkg::HSEL_W-1:0]     in_hidx;
    logic [msp_pkg::HSEL_W-1:0]     cur_hidx;

    msp_pkg::link_req_t             link_req;
    logic [msp_pkg::PTR_W-1:0]      link_q;
    logic                           data_we;
    logic                           data_re;
    logic [msp_pkg::IDX_W-1:0]      data_raddr;
    logic [msp_pkg::DATA_W-1:0]     data_q;

    msp_link_store u_link (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (link_req),
        .rdata (link_q)
    );

    msp_ram #(
        .WIDTH (msp_pkg::DATA_W),
        .DEPTH (msp_pkg::POOL_SLOTS)
    ) u_data_ram (
        .clk   (clk),
        .we    (data_we),
        .waddr (slot_reg[msp_pkg::IDX_W-1:0]),
        .wdata (value_reg),
        .re    (data_re),
        .raddr (data_raddr),
        .rdata (data_q)
    );

    assign busy     = (state_reg != msp_pkg::S_IDLE);
    assign accept   = start && !busy;
    assign in_hidx  = stack_sel[msp_pkg::HSEL_W-1:0];
    assign cur_hidx = sel_reg[msp_pkg::HSEL_W-1:0];
    assign in_sel_ok = (32'(stack_sel) < 32'(msp_pkg::NUM_STACKS));
    assign in_head  = stack_head_reg[in_hidx];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= msp_pkg::S_IDLE;
            free_head_reg <= '0;
            ok_reg        <= 1'b0;
            done_reg      <= 1'b0;
            status_reg    <= msp_pkg::STAT_DONE;
            for (int i = 0; i < msp_pkg::NUM_STACKS; i++)
            begin
                stack_head_reg[i] <= msp_pkg::NULL_PTR;
            end
        end
        else
        begin
            state_reg      <= state_next;
            free_head_reg  <= free_head_next;
            ok_reg         <= ok_next;
            done_reg       <= done_next;
            status_reg     <= status_next;
            stack_head_reg <= stack_head_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pop_value_reg <= pop_value_next;
        slot_reg      <= slot_next;
        if (accept)
        begin
            kind_reg  <= msp_pkg::kind_t'(kind);
            sel_reg   <= stack_sel;
            value_reg <= push_value;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        stack_head_next = stack_head_reg;
        free_head_next  = free_head_reg;
        ok_next         = ok_reg;
        slot_next       = slot_reg;
        done_next       = 1'b0;
        status_next     = status_reg;
        pop_value_next  = pop_value_reg;
        link_req        = '0;
        data_we         = 1'b0;
        data_re         = 1'b0;
        data_raddr      = in_head[msp_pkg::IDX_W-1:0];

        case (state_reg)
            msp_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (msp_pkg::kind_t'(kind) == msp_pkg::KIND_PUSH)
                    begin
                        slot_next = free_head_reg;
                        ok_next   = in_sel_ok && (free_head_reg < msp_pkg::NULL_PTR);
                    end
                    else
                    begin
                        slot_next = in_head;
                        ok_next   = in_sel_ok && (in_head < msp_pkg::NULL_PTR);
                        data_re   = ok_next;
                    end
                    link_req.re    = ok_next;
                    link_req.raddr = slot_next[msp_pkg::IDX_W-1:0];
                    state_next     = msp_pkg::S_COMMIT;
                end
            end
            msp_pkg::S_COMMIT:
            begin
                done_next      = 1'b1;
                pop_value_next = '0;
                link_req.waddr = slot_reg[msp_pkg::IDX_W-1:0];
                if (kind_reg == msp_pkg::KIND_PUSH)
                begin
                    if (ok_reg)
                    begin
                        free_head_next            = link_q;
                        data_we                   = 1'b1;
                        link_req.we               = 1'b1;
                        link_req.wdata            = stack_head_reg[cur_hidx];
                        stack_head_next[cur_hidx] = slot_reg;
                        status_next               = msp_pkg::STAT_DONE;
                    end
                    else
                    begin
                        status_next = msp_pkg::STAT_FULL;
                    end
                end
                else
                begin
                    if (ok_reg)
                    begin
                        stack_head_next[cur_hidx] = link_q;
                        link_req.we               = 1'b1;
                        link_req.wdata            = free_head_reg;
                        free_head_next            = slot_reg;
                        pop_value_next            = data_q;
                        status_next               = msp_pkg::STAT_DONE;
                    end
                    else
                    begin
                        status_next = msp_pkg::STAT_EMPTY;
                    end
                end
                state_next = msp_pkg::S_IDLE;
            end
            default:
            begin
                state_next = msp_pkg::S_IDLE;
            end
        endcase
    end

    assign done      = done_reg;
    assign status    = status_reg;
    assign pop_value = pop_value_reg;

`ifndef SYNTHESIS
    a_commit_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == msp_pkg::S_COMMIT) |=> done_reg)
        else $error("commit cycle did not produce a result word");

    a_accept_to_commit: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (state_reg == msp_pkg::S_COMMIT))
        else $error("accepted word did not move to commit");

    a_fail_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (status_reg != msp_pkg::STAT_DONE)) |-> (pop_value_reg == '0))
        else $error("failed operation returned a nonzero value");

    a_push_moves_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == msp_pkg::S_COMMIT && ok_reg && kind_reg == msp_pkg::KIND_PUSH)
        |=> (free_head_reg != $past(free_head_reg)))
        else $error("successful push left the free head in place");

    a_result_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy)
        else $error("result word shown while busy");
`endif

endmodule

`default_nettype wire

FILE: sv/msp_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; used for the slot data and slot link stores.
`default_nettype none

module msp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: sv/msp_link_store.sv
// Slot link store: a link RAM plus one valid bit per slot, so that an unwritten
// slot reads as its reset link (the next slot). Depends on msp_pkg and msp_ram.
`default_nettype none

module msp_link_store (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire msp_pkg::link_req_t        req,
    output logic [msp_pkg::PTR_W-1:0]      rdata
);

    logic [msp_pkg::POOL_SLOTS-1:0] valid_reg;
    logic                           hit_reg;
    logic [msp_pkg::PTR_W-1:0]      dflt_reg;
    logic [msp_pkg::PTR_W-1:0]      ram_q;

    msp_ram #(
        .WIDTH (msp_pkg::PTR_W),
        .DEPTH (msp_pkg::POOL_SLOTS)
    ) u_link_ram (
        .clk   (clk),
        .we    (req.we),
        .waddr (req.waddr),
        .wdata (req.wdata),
        .re    (req.re),
        .raddr (req.raddr),
        .rdata (ram_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (req.we)
        begin
            valid_reg[req.waddr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            hit_reg  <= valid_reg[req.raddr];
            dflt_reg <= msp_pkg::PTR_W'(req.raddr) + msp_pkg::PTR_W'(1);
        end
    end

    assign rdata = hit_reg ? ram_q : dflt_reg;

endmodule

`default_nettype wire

FILE: verif/testbench.sv
// Self-checking testbench for multi_stack_shared_pool: pushes and pops on all stacks,
// predicted in step with the block and checked word by word against its results.
// Depends on msp_pkg and the block's RTL.
`default_nettype none

module testbench;

    import msp_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_OPS  = 550;

    typedef struct {
        kind_t            op;
        logic [SEL_W-1:0] sel;
        logic [31:0]      value;
        int unsigned      gap;
        bit               drain;
    } stack_op_t;

    typedef struct {
        status_t     st;
        logic [31:0] word;
    } reply_t;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic              kind;
    logic [SEL_W-1:0]  stack_sel;
    logic [31:0]       push_value;
    logic              done;
    logic [1:0]        status;
    logic [31:0]       pop_value;

    multi_stack_shared_pool u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .kind       (kind),
        .stack_sel  (stack_sel),
        .push_value (push_value),
        .done       (done),
        .status     (status),
        .pop_value  (pop_value)
    );

    stack_op_t         pending_ops[$];
    reply_t            replies_due[$];
    stack_op_t         next_op;
    bit                took;
    int unsigned       idle_count;
    int unsigned       mismatches;
    int unsigned       cycle_count;

    logic [DATA_W-1:0] slot_word[POOL_SLOTS];
    logic [PTR_W-1:0]  slot_next[POOL_SLOTS];
    logic [PTR_W-1:0]  head_of[NUM_STACKS];
    logic [PTR_W-1:0]  free_top;

    int unsigned       depth[NUM_STACKS];
    int unsigned       used;
    int unsigned       gap_style;
    bit                hold_next;

    always #5 clk = ~clk;

    function automatic reply_t pool_apply(input stack_op_t o);
        reply_t           r;
        logic [PTR_W-1:0] slot;
        r.st = STAT_DONE;
        r.word = '0;
        if (o.op == KIND_PUSH)
        begin
            slot = free_top;
            if (int'(o.sel) >= NUM_STACKS || slot >= NULL_PTR)
            begin
                r.st = STAT_FULL;
            end
            else
            begin
                free_top = slot_next[slot[IDX_W-1:0]];
                slot_word[slot[IDX_W-1:0]] = o.value;
                slot_next[slot[IDX_W-1:0]] = head_of[o.sel[HSEL_W-1:0]];
                head_of[o.sel[HSEL_W-1:0]] = slot;
            end
        end
        else
        begin
            slot = (int'(o.sel) < NUM_STACKS) ? head_of[o.sel[HSEL_W-1:0]] : NULL_PTR;
            if (slot >= NULL_PTR)
            begin
                r.st = STAT_EMPTY;
            end
            else
            begin
                head_of[o.sel[HSEL_W-1:0]] = slot_next[slot[IDX_W-1:0]];
                slot_next[slot[IDX_W-1:0]] = free_top;
                free_top = slot;
                r.word = slot_word[slot[IDX_W-1:0]];
            end
        end
        return r;
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 32'h0000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h8000_0000;
            3: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_op(input kind_t k, input int unsigned s, input logic [31:0] v);
        stack_op_t o;
        o.op = k;
        o.sel = s[SEL_W-1:0];
        o.value = v;
        o.drain = hold_next;
        hold_next = 1'b0;
        case (gap_style)
            0: o.gap = 0;
            1: o.gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 17) : 0;
            default: o.gap = $urandom_range(0, 17);
        endcase
        if (k == KIND_PUSH)
        begin
            if (used < POOL_SLOTS)
            begin
                depth[s]++;
                used++;
            end
        end
        else if (depth[s] > 0)
        begin
            depth[s]--;
            used--;
        end
        pending_ops.push_back(o);
    endtask

    always @(negedge clk)
    begin
        if (rst_n && (!start || took))
        begin
            if (pending_ops.size() == 0)
            begin
                start <= 1'b0;
            end
            else if (pending_ops[0].drain && replies_due.size() != 0)
            begin
                start <= 1'b0;
            end
            else if (idle_count < pending_ops[0].gap)
            begin
                start <= 1'b0;
                idle_count++;
            end
            else
            begin
                next_op = pending_ops.pop_front();
                kind <= next_op.op;
                stack_sel <= next_op.sel;
                push_value <= next_op.value;
                start <= 1'b1;
                idle_count = 0;
            end
        end
    end

    always @(posedge clk)
    begin
        stack_op_t seen;
        reply_t    want;
        if (rst_n)
        begin
            took = start && !busy;
            if (took)
            begin
                seen.op = kind_t'(kind);
                seen.sel = stack_sel;
                seen.value = push_value;
                seen.gap = 0;
                seen.drain = 1'b0;
                replies_due.push_back(pool_apply(seen));
            end
            if (done)
            begin
                if (replies_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result word: status %0d value %h",
                                 status, pop_value);
                end
                else
                begin
                    want = replies_due.pop_front();
                    if (status !== want.st || pop_value !== want.word)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: expected status %0d value %h, ",
                                      "got status %0d value %h"},
                                     want.st, want.word, status, pop_value);
                    end
                end
            end
        end
        else
        begin
            took = 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        int unsigned phase;
        int unsigned s;
        int unsigned hot;
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        kind = 1'b0;
        stack_sel = '0;
        push_value = '0;
        took = 1'b0;
        idle_count = 0;
        mismatches = 0;
        cycle_count = 0;
        used = 0;
        hold_next = 1'b0;
        gap_style = 1;
        for (int i = 0; i < POOL_SLOTS; i++)
        begin
            slot_word[i] = '0;
            slot_next[i] = PTR_W'(i + 1);
        end
        for (int i = 0; i < NUM_STACKS; i++)
        begin
            head_of[i] = NULL_PTR;
            depth[i] = 0;
        end
        free_top = '0;

        add_op(KIND_POP, 0, pick_word());
        add_op(KIND_PUSH, 0, 32'h7fff_ffff);
        add_op(KIND_PUSH, 0, 32'h8000_0000);
        add_op(KIND_PUSH, 7, 32'h0000_0000);
        add_op(KIND_PUSH, 7, 32'hffff_ffff);
        add_op(KIND_POP, 0, 32'hffff_ffff);
        add_op(KIND_POP, 0, 32'h0000_0000);
        add_op(KIND_POP, 0, pick_word());
        add_op(KIND_POP, 7, pick_word());
        add_op(KIND_POP, 7, pick_word());
        add_op(KIND_POP, 7, pick_word());
        for (int i = 1; i < 7; i++)
            add_op(KIND_PUSH, i, $urandom);
        for (int i = 6; i > 0; i--)
            add_op(KIND_POP, i, $urandom);

        phase = 0;
        while (pending_ops.size() < 23 + RANDOM_OPS)
        begin
            gap_style = $urandom_range(0, 2);
            hold_next = (phase == 0) || ($urandom_range(0, 2) == 0);
            case (phase % 4)
                0:
                begin
                    while (used < POOL_SLOTS)
                    begin
                        s = $urandom_range(0, NUM_STACKS - 1);
                        if ($urandom_range(0, 9) != 0)
                            add_op(KIND_PUSH, s, pick_word());
                        else
                            add_op(KIND_POP, s, pick_word());
                    end
                    repeat ($urandom_range(2, 4))
                        add_op(KIND_PUSH, $urandom_range(0, NUM_STACKS - 1), pick_word());
                end
                2:
                begin
                    while (used > 0)
                    begin
                        s = $urandom_range(0, NUM_STACKS - 1);
                        if ($urandom_range(0, 4) != 0)
                        begin
                            while (depth[s] == 0)
                                s = $urandom_range(0, NUM_STACKS - 1);
                        end
                        add_op(KIND_POP, s, pick_word());
                    end
                    repeat ($urandom_range(1, 3))
                        add_op(KIND_POP, $urandom_range(0, NUM_STACKS - 1), pick_word());
                end
                default:
                begin
                    hot = $urandom_range(0, NUM_STACKS - 1);
                    repeat (60)
                    begin
                        s = ($urandom_range(0, 2) == 0) ?
                            $urandom_range(0, NUM_STACKS - 1) : hot;
                        if ($urandom_range(0, 1) == 0)
                            add_op(KIND_PUSH, s, pick_word());
                        else
                            add_op(KIND_POP, s, pick_word());
                    end
                end
            endcase
            phase++;
        end

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_ops.size() != 0 || start || replies_due.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
